FILE: design/sre_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sre_pkg: shared types and constants of the stepper rate frame encoder
// Widths, frame layout, register indexes and controller/datapath structs.
// ----------------------------------------------------------------------------
package sre_pkg;

  localparam int BYTE_W     = 8;
  localparam int STEP_W     = 16;
  localparam int NUM_W      = 32;
  localparam int RATE_INT_W = 24;
  localparam int FRAC_W     = 8;
  localparam int RATE_W     = RATE_INT_W + FRAC_W;
  localparam int SERVO_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int NUM_AXES = 3;
  localparam int AXIS_W   = 2;
  localparam logic [AXIS_W-1:0] AXIS_LAST = AXIS_W'(NUM_AXES - 1);

  // Outgoing frame
  localparam int FRAME_LEN = 19;
  localparam int IDX_W     = $clog2(FRAME_LEN);
  localparam logic [IDX_W-1:0] IDX_HDR        = IDX_W'(0);
  localparam logic [IDX_W-1:0] IDX_RATE_LAST  = IDX_W'(4 * NUM_AXES);
  localparam logic [IDX_W-1:0] IDX_DIRS       = IDX_W'(4 * NUM_AXES + 1);
  localparam logic [IDX_W-1:0] IDX_SERVO_A_LO = IDX_W'(4 * NUM_AXES + 2);
  localparam logic [IDX_W-1:0] IDX_SERVO_A_HI = IDX_W'(4 * NUM_AXES + 3);
  localparam logic [IDX_W-1:0] IDX_SERVO_B_LO = IDX_W'(4 * NUM_AXES + 4);
  localparam logic [IDX_W-1:0] IDX_SERVO_B_HI = IDX_W'(4 * NUM_AXES + 5);
  localparam logic [IDX_W-1:0] IDX_LAST       = IDX_W'(FRAME_LEN - 1);

  // Incoming frame
  localparam int RXC_W = 4;
  localparam logic [RXC_W-1:0] RX_FRAME_LEN = RXC_W'(8);

  localparam logic [BYTE_W-1:0] HDR_BYTE  = 8'hA5;
  localparam logic [BYTE_W-1:0] TAIL_BYTE = 8'h5A;

  // Divider
  localparam int DIVIDEND_W = NUM_W + FRAC_W;
  localparam int DIV_STEPS  = 2;
  localparam int DIV_ITERS  = DIVIDEND_W / DIV_STEPS;
  localparam int DIV_CNT_W  = $clog2(DIV_ITERS);
  localparam logic [DIVIDEND_W:0] RATE_ONE = (DIVIDEND_W + 1)'(256);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_NUM = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_MAX = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_MIN = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SERVO_A  = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_SERVO_B  = CFG_IDX_W'(4);

  localparam logic [NUM_W-1:0]      RST_RATE_NUM = NUM_W'(1000000);
  localparam logic [RATE_INT_W-1:0] RST_RATE_MAX = 24'hFFFFFF;
  localparam logic [RATE_INT_W-1:0] RST_RATE_MIN = 24'h000000;
  localparam logic [SERVO_W-1:0]    RST_SERVO    = SERVO_W'(500);

  typedef struct packed {
    logic              load_steps;
    logic              div_start;
    logic              store_rate;
    logic              emit;
    logic [AXIS_W-1:0] axis;
    logic [IDX_W-1:0]  byte_idx;
  } ctrl_cmd_t;

  typedef struct packed {
    logic hdr_seen;
    logic tail_seen;
    logic div_done;
    logic out_free;
  } dp_sts_t;

endpackage

FILE: design/sre_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sre_if: channel interfaces of the stepper rate frame encoder
// Input item channel, result byte channel and register write channel.
// ----------------------------------------------------------------------------
interface sre_in_if;
  logic                              valid;
  logic                              ready;
  logic        [sre_pkg::BYTE_W-1:0] rx_byte;
  logic signed [sre_pkg::STEP_W-1:0] steps_axis0;
  logic signed [sre_pkg::STEP_W-1:0] steps_axis1;
  logic signed [sre_pkg::STEP_W-1:0] steps_axis2;

  modport source (output valid, rx_byte, steps_axis0, steps_axis1, steps_axis2,
                  input ready);
  modport sink (input valid, rx_byte, steps_axis0, steps_axis1, steps_axis2,
                output ready);
endinterface

interface sre_out_if;
  logic                       valid;
  logic                       ready;
  logic [sre_pkg::BYTE_W-1:0] tx_byte;
  logic                       last_byte;

  modport source (output valid, tx_byte, last_byte, input ready);
  modport sink (input valid, tx_byte, last_byte, output ready);
endinterface

interface sre_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [sre_pkg::CFG_IDX_W-1:0]  index;
  logic [sre_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: design/sre_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sre_div: iterative unsigned divider
// Restoring division, two quotient bits per cycle, result on done pulse.
// ----------------------------------------------------------------------------
module sre_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [sre_pkg::DIVIDEND_W-1:0]     dividend_i,
  input  logic [sre_pkg::STEP_W-1:0]         divisor_i,
  output logic                               done_o,
  output logic [sre_pkg::DIVIDEND_W-1:0]     quot_o
);

  logic                              busy_q, busy_d;
  logic                              done_q, done_d;
  logic [sre_pkg::DIV_CNT_W-1:0]     cnt_q, cnt_d;
  logic [sre_pkg::DIVIDEND_W-1:0]    acc_q, acc_d;
  logic [sre_pkg::STEP_W-1:0]        rem_q, rem_d;
  logic [sre_pkg::STEP_W-1:0]        dvs_q, dvs_d;

  always_comb begin
    logic [sre_pkg::DIVIDEND_W-1:0] acc_n;
    logic [sre_pkg::STEP_W-1:0]     rem_n;
    logic [sre_pkg::STEP_W:0]       part;
    acc_n  = acc_q;
    rem_n  = rem_q;
    part   = '0;
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvs_d  = dvs_q;
    // shift in one dividend bit, subtract when it fits
    for (int i = 0; i < sre_pkg::DIV_STEPS; i++) begin
      part  = {rem_n, acc_n[sre_pkg::DIVIDEND_W-1]};
      acc_n = {acc_n[sre_pkg::DIVIDEND_W-2:0], 1'b0};
      if (part >= {1'b0, dvs_q}) begin
        part     = part - {1'b0, dvs_q};
        acc_n[0] = 1'b1;
      end
      rem_n = part[sre_pkg::STEP_W-1:0];
    end
    acc_d = acc_q;
    rem_d = rem_q;
    if (start_i) begin
      acc_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = sre_pkg::DIV_CNT_W'(sre_pkg::DIV_ITERS - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = acc_n;
      rem_d = rem_n;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = acc_q;

  a_done_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while still busy");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");
  a_busy_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && cnt_q != '0 && !start_i) |=> busy_q)
    else $error("divider stopped early");

endmodule

FILE: design/sre_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sre_dp: datapath of the stepper rate frame encoder
// Registers, step magnitudes, rate division and clamp, frame byte output.
// ----------------------------------------------------------------------------
module sre_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  sre_pkg::ctrl_cmd_t                  cmd_i,
  output sre_pkg::dp_sts_t                    sts_o,
  input  logic        [sre_pkg::BYTE_W-1:0]   rx_byte_i,
  input  logic signed [sre_pkg::STEP_W-1:0]   steps_axis0_i,
  input  logic signed [sre_pkg::STEP_W-1:0]   steps_axis1_i,
  input  logic signed [sre_pkg::STEP_W-1:0]   steps_axis2_i,
  input  logic                                cfg_we_i,
  input  logic        [sre_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic        [sre_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic        [sre_pkg::BYTE_W-1:0]   tx_byte_o,
  output logic                                last_byte_o
);

  logic [sre_pkg::NUM_W-1:0]      num_q;
  logic [sre_pkg::RATE_INT_W-1:0] rmax_q;
  logic [sre_pkg::RATE_INT_W-1:0] rmin_q;
  logic [sre_pkg::SERVO_W-1:0]    servo_a_q;
  logic [sre_pkg::SERVO_W-1:0]    servo_b_q;

  logic [sre_pkg::STEP_W-1:0]     mag_q [sre_pkg::NUM_AXES];
  logic [sre_pkg::NUM_AXES-1:0]   dirs_q;
  logic [sre_pkg::RATE_W-1:0]     rate_q [sre_pkg::NUM_AXES];

  logic                           out_valid_q;
  logic [sre_pkg::BYTE_W-1:0]     tx_byte_q, tx_byte_d;
  logic                           last_q;

  logic                           div_done;
  logic [sre_pkg::DIVIDEND_W-1:0] div_q;
  logic [sre_pkg::RATE_W-1:0]     rate_new;
  logic [sre_pkg::STEP_W-1:0]     steps [sre_pkg::NUM_AXES];

  assign steps[0] = steps_axis0_i;
  assign steps[1] = steps_axis1_i;
  assign steps[2] = steps_axis2_i;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q     <= sre_pkg::RST_RATE_NUM;
      rmax_q    <= sre_pkg::RST_RATE_MAX;
      rmin_q    <= sre_pkg::RST_RATE_MIN;
      servo_a_q <= sre_pkg::RST_SERVO;
      servo_b_q <= sre_pkg::RST_SERVO;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sre_pkg::CFG_RATE_NUM: num_q     <= cfg_data_i;
        sre_pkg::CFG_RATE_MAX: rmax_q    <= cfg_data_i[sre_pkg::RATE_INT_W-1:0];
        sre_pkg::CFG_RATE_MIN: rmin_q    <= cfg_data_i[sre_pkg::RATE_INT_W-1:0];
        sre_pkg::CFG_SERVO_A:  servo_a_q <= cfg_data_i[sre_pkg::SERVO_W-1:0];
        sre_pkg::CFG_SERVO_B:  servo_b_q <= cfg_data_i[sre_pkg::SERVO_W-1:0];
        default: ;
      endcase
    end
  end

  // Step magnitudes and direction bits of the frame-closing item
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_steps) begin
      for (int k = 0; k < sre_pkg::NUM_AXES; k++) begin
        mag_q[k]  <= steps[k][sre_pkg::STEP_W-1] ? (~steps[k] + 1'b1) : steps[k];
        dirs_q[k] <= ~steps[k][sre_pkg::STEP_W-1];
      end
    end
  end

  sre_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i ({num_q, {sre_pkg::FRAC_W{1'b0}}}),
    .divisor_i  (mag_q[cmd_i.axis]),
    .done_o     (div_done),
    .quot_o     (div_q)
  );

  // Rate = quotient - 1.0, clamped; max test first, min test inclusive; zero steps give the larger bound
  always_comb begin
    logic [sre_pkg::RATE_W-1:0]     hi, lo;
    logic [sre_pkg::DIVIDEND_W:0]   q_ext, hi_p, lo_p;
    hi    = {rmax_q, {sre_pkg::FRAC_W{1'b0}}};
    lo    = {rmin_q, {sre_pkg::FRAC_W{1'b0}}};
    q_ext = {1'b0, div_q};
    hi_p  = (sre_pkg::DIVIDEND_W + 1)'(hi) + sre_pkg::RATE_ONE;
    lo_p  = (sre_pkg::DIVIDEND_W + 1)'(lo) + sre_pkg::RATE_ONE;
    if (mag_q[cmd_i.axis] == '0) begin
      rate_new = (hi <= lo) ? lo : hi;
    end else if (q_ext > hi_p) begin
      rate_new = hi;
    end else if (q_ext <= lo_p) begin
      rate_new = lo;
    end else begin
      rate_new = sre_pkg::RATE_W'(q_ext - sre_pkg::RATE_ONE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store_rate) begin
      rate_q[cmd_i.axis] <= rate_new;
    end
  end

  // Frame byte select
  always_comb begin
    logic [sre_pkg::IDX_W-1:0]  off;
    logic [sre_pkg::AXIS_W-1:0] ax;
    logic [sre_pkg::RATE_W-1:0] rsel;
    off  = cmd_i.byte_idx - 1'b1;
    ax   = sre_pkg::AXIS_W'(off >> 2);
    rsel = rate_q[ax];
    if (cmd_i.byte_idx == sre_pkg::IDX_HDR) begin
      tx_byte_d = sre_pkg::HDR_BYTE;
    end else if (cmd_i.byte_idx <= sre_pkg::IDX_RATE_LAST) begin
      unique case (off[1:0])
        2'd0: tx_byte_d = rsel[15:8];
        2'd1: tx_byte_d = rsel[23:16];
        2'd2: tx_byte_d = rsel[31:24];
        default: tx_byte_d = rsel[7:0];
      endcase
    end else if (cmd_i.byte_idx == sre_pkg::IDX_DIRS) begin
      tx_byte_d = sre_pkg::BYTE_W'(dirs_q);
    end else if (cmd_i.byte_idx == sre_pkg::IDX_SERVO_A_LO) begin
      tx_byte_d = servo_a_q[7:0];
    end else if (cmd_i.byte_idx == sre_pkg::IDX_SERVO_A_HI) begin
      tx_byte_d = servo_a_q[15:8];
    end else if (cmd_i.byte_idx == sre_pkg::IDX_SERVO_B_LO) begin
      tx_byte_d = servo_b_q[7:0];
    end else if (cmd_i.byte_idx == sre_pkg::IDX_SERVO_B_HI) begin
      tx_byte_d = servo_b_q[15:8];
    end else if (cmd_i.byte_idx == sre_pkg::IDX_LAST) begin
      tx_byte_d = sre_pkg::TAIL_BYTE;
    end else begin
      tx_byte_d = '0;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      tx_byte_q <= tx_byte_d;
      last_q    <= (cmd_i.byte_idx == sre_pkg::IDX_LAST);
    end
  end

  assign out_valid_o = out_valid_q;
  assign tx_byte_o   = tx_byte_q;
  assign last_byte_o = last_q;

  assign sts_o.hdr_seen  = (rx_byte_i == sre_pkg::HDR_BYTE);
  assign sts_o.tail_seen = (rx_byte_i == sre_pkg::TAIL_BYTE);
  assign sts_o.div_done  = div_done;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

endmodule

FILE: design/sre_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sre_ctrl: controller of the stepper rate frame encoder
// Hunts incoming frames, sequences the three divisions and the frame output.
// ----------------------------------------------------------------------------
module sre_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sre_pkg::dp_sts_t   sts_i,
  output sre_pkg::ctrl_cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE     = 2'd0;
  localparam logic [1:0] S_DIV_GO   = 2'd1;
  localparam logic [1:0] S_DIV_WAIT = 2'd2;
  localparam logic [1:0] S_EMIT     = 2'd3;

  logic [1:0]                   state_q, state_d;
  logic [sre_pkg::AXIS_W-1:0]   axis_q, axis_d;
  logic [sre_pkg::IDX_W-1:0]    idx_q, idx_d;
  logic                         in_frame_q, in_frame_d;
  logic [sre_pkg::RXC_W-1:0]    rx_cnt_q, rx_cnt_d;
  logic [sre_pkg::RXC_W-1:0]    cnt_inc;
  logic                         accept;
  logic                         fire;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign cnt_inc    = rx_cnt_q + 1'b1;

  // Incoming frame tracker
  always_comb begin
    in_frame_d = in_frame_q;
    rx_cnt_d   = rx_cnt_q;
    fire       = 1'b0;
    if (accept) begin
      if (!in_frame_q) begin
        if (sts_i.hdr_seen) begin
          in_frame_d = 1'b1;
          rx_cnt_d   = sre_pkg::RXC_W'(1);
        end else begin
          rx_cnt_d = '0;
        end
      end else if (cnt_inc != sre_pkg::RX_FRAME_LEN && cnt_inc <= sre_pkg::RX_FRAME_LEN) begin
        rx_cnt_d = cnt_inc;
      end else begin
        // frame closed or overrun: back to hunting
        in_frame_d = 1'b0;
        rx_cnt_d   = '0;
        fire       = (cnt_inc == sre_pkg::RX_FRAME_LEN) && sts_i.tail_seen;
      end
    end
  end

  always_comb begin
    state_d          = state_q;
    axis_d           = axis_q;
    idx_d            = idx_q;
    cmd_o.load_steps = 1'b0;
    cmd_o.div_start  = 1'b0;
    cmd_o.store_rate = 1'b0;
    cmd_o.emit       = 1'b0;
    cmd_o.axis       = axis_q;
    cmd_o.byte_idx   = idx_q;
    unique case (state_q)
      S_IDLE: begin
        if (fire) begin
          cmd_o.load_steps = 1'b1;
          axis_d           = '0;
          state_d          = S_DIV_GO;
        end
      end
      S_DIV_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.store_rate = 1'b1;
          if (axis_q == sre_pkg::AXIS_LAST) begin
            idx_d   = '0;
            state_d = S_EMIT;
          end else begin
            axis_d  = axis_q + 1'b1;
            state_d = S_DIV_GO;
          end
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (idx_q == sre_pkg::IDX_LAST) begin
            state_d = S_IDLE;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      axis_q     <= '0;
      idx_q      <= '0;
      in_frame_q <= 1'b0;
      rx_cnt_q   <= '0;
    end else begin
      state_q    <= state_d;
      axis_q     <= axis_d;
      idx_q      <= idx_d;
      in_frame_q <= in_frame_d;
      rx_cnt_q   <= rx_cnt_d;
    end
  end

  a_hunt_count_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_frame_q |-> rx_cnt_q == '0)
    else $error("count nonzero while hunting");
  a_frame_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_frame_q |-> (rx_cnt_q != '0 && rx_cnt_q < sre_pkg::RX_FRAME_LEN))
    else $error("frame count out of range");
  a_emit_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> sts_i.out_free)
    else $error("byte emitted into a full output register");
  a_last_rate_to_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.store_rate && axis_q == sre_pkg::AXIS_LAST) |=>
      (state_q == S_EMIT && idx_q == '0))
    else $error("frame output did not start after last rate");

endmodule

FILE: design/stepper_rate_frame_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_rate_frame_encoder: SPI command frame hunter and rate frame encoder
// Turns a closing receive frame into a 19-byte command frame of axis rates.
// ----------------------------------------------------------------------------
// While idle, items that do not close a frame are taken one per cycle.
// A frame-closing item starts three divisions in turn, each of 20 two-bit
// iterations of one shared divider between start and store; the first frame
// byte enters the output register after the third rate is stored.
// The 19 bytes follow one per cycle while the sink is ready; the next item is
// taken once the last byte sits in the output register.
// Reset (rst_ni low, asynchronous) restores the register defaults and hunting.
module stepper_rate_frame_encoder (
  input  logic      clk_i,
  input  logic      rst_ni,
  sre_in_if.sink    in_i,
  sre_out_if.source out_o,
  sre_cfg_if.sink   cfg_i
);

  sre_pkg::ctrl_cmd_t cmd;
  sre_pkg::dp_sts_t   sts;

  assign cfg_i.ready = 1'b1;

  sre_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sre_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .rx_byte_i     (in_i.rx_byte),
    .steps_axis0_i (in_i.steps_axis0),
    .steps_axis1_i (in_i.steps_axis1),
    .steps_axis2_i (in_i.steps_axis2),
    .cfg_we_i      (cfg_i.valid),
    .cfg_idx_i     (cfg_i.index),
    .cfg_data_i    (cfg_i.data),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .tx_byte_o     (out_o.tx_byte),
    .last_byte_o   (out_o.last_byte)
  );

endmodule
